// ===== hdl/tmg_pkg.sv =====
// Shared constants, codes, types and a helper function for the text-mode glyph row renderer.
package tmg_pkg;

	// Geometry of the font and the screen.
	localparam int GLYPH_HEIGHT = 16;
	localparam int NUM_COLUMNS  = 80;
	localparam int MAX_ROWS     = 64;

	// The font store always holds sixteen row slots for each of 256 glyphs.
	localparam int STORE_ROWS   = 16;
	localparam int GLYPH_COUNT  = 256;
	localparam int STORE_DEPTH  = GLYPH_COUNT * STORE_ROWS;
	localparam int STORE_AW     = $clog2(STORE_DEPTH);

	// Field widths.
	localparam int OP_W     = 2;
	localparam int GLYPH_W  = 8;
	localparam int GROW_W   = 4;
	localparam int FONT_W   = 8;
	localparam int TROW_W   = 6;
	localparam int COL_W    = 7;
	localparam int COLOR_W  = 4;
	localparam int PIX_W    = FONT_W * COLOR_W;
	localparam int SPEED_W  = 8;
	localparam int RIU_W    = 7;
	localparam int BLINK_W  = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Item operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_FONT_WRITE = 2'd0,
		OP_FRAME_TICK = 2'd1,
		OP_RENDER     = 2'd2
	} op_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CURSOR_ENABLE = 3'd0,
		CFG_BLINK_SPEED   = 3'd1,
		CFG_CURSOR_ROW    = 3'd2,
		CFG_CURSOR_COL    = 3'd3,
		CFG_CURSOR_FORE   = 3'd4,
		CFG_CURSOR_BACK   = 3'd5,
		CFG_ROWS_IN_USE   = 3'd6
	} cfg_idx_t;

	// Configuration register file contents.
	typedef struct packed {
		logic                 cursor_enable;
		logic [SPEED_W-1:0]   blink_speed;
		logic [TROW_W-1:0]    cursor_row;
		logic [COL_W-1:0]     cursor_col;
		logic [COLOR_W-1:0]   cursor_fore;
		logic [COLOR_W-1:0]   cursor_back;
		logic [RIU_W-1:0]     rows_in_use;
	} cfg_t;

	// Render word after the first stage: everything the shading stage needs
	// besides the font row coming out of the store.
	typedef struct packed {
		logic                 blanked;
		logic [COLOR_W-1:0]   fg;
		logic [COLOR_W-1:0]   bg;
		logic                 row_ok;
		logic                 blank;
		logic                 bold;
		logic                 ul_fill;
	} render_t;

	// Turn a row of glyph bits into eight color indices; bit k lands in nibble k,
	// so the leftmost pixel (bit 7) ends up in the top nibble.
	function automatic logic [PIX_W-1:0] spread_pixels(
		input logic [FONT_W-1:0]  bits,
		input logic [COLOR_W-1:0] fg,
		input logic [COLOR_W-1:0] bg
	);
		logic [PIX_W-1:0] acc;
		acc = '0;
		for (int k = 0; k < FONT_W; k++) begin
			acc[k*COLOR_W +: COLOR_W] = bits[k] ? fg : bg;
		end
		return acc;
	endfunction

endpackage

// ===== hdl/tmg_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module tmg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/tmg_ctrl.sv =====
// Configuration registers and the cursor blink counter.
module tmg_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [tmg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tmg_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                         tick,
	output tmg_pkg::cfg_t                cfg,
	output logic                         blink_on
);
	import tmg_pkg::*;

	cfg_t                      cfg_q;
	logic signed [BLINK_W-1:0] blink_q;
	logic signed [BLINK_W:0]   blink_inc;
	logic signed [BLINK_W:0]   speed_ext;

	// One bit of headroom so a counter left above a lowered speed still compares right.
	assign blink_inc = {blink_q[BLINK_W-1], blink_q} + (BLINK_W+1)'(1);
	assign speed_ext = $signed({(BLINK_W+1-SPEED_W)'(0), cfg_q.blink_speed});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cursor_enable <= 1'b0;
			cfg_q.blink_speed   <= SPEED_W'(20);
			cfg_q.cursor_row    <= '0;
			cfg_q.cursor_col    <= '0;
			cfg_q.cursor_fore   <= '0;
			cfg_q.cursor_back   <= COLOR_W'(15);
			cfg_q.rows_in_use   <= RIU_W'(25);
			blink_q             <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_CURSOR_ENABLE: cfg_q.cursor_enable <= cfg_data[0];
					CFG_BLINK_SPEED:   cfg_q.blink_speed   <= cfg_data[SPEED_W-1:0];
					CFG_CURSOR_ROW:    cfg_q.cursor_row    <= cfg_data[TROW_W-1:0];
					CFG_CURSOR_COL:    cfg_q.cursor_col    <= cfg_data[COL_W-1:0];
					CFG_CURSOR_FORE:   cfg_q.cursor_fore   <= cfg_data[COLOR_W-1:0];
					CFG_CURSOR_BACK:   cfg_q.cursor_back   <= cfg_data[COLOR_W-1:0];
					CFG_ROWS_IN_USE:   cfg_q.rows_in_use   <= cfg_data[RIU_W-1:0];
					default: ;
				endcase
			end
			if (tick && cfg_q.cursor_enable) begin
				if (blink_inc >= speed_ext) begin
					blink_q <= BLINK_W'(-speed_ext);
				end else begin
					blink_q <= blink_inc[BLINK_W-1:0];
				end
			end
		end
	end

	assign cfg      = cfg_q;
	assign blink_on = !blink_q[BLINK_W-1];

endmodule

// ===== hdl/tmg_pixel.sv =====
// Shading stage: applies blank, bold and underline to the font row and holds the output word.
module tmg_pixel (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s1_valid,
	input  tmg_pkg::render_t               s1,
	input  logic [tmg_pkg::FONT_W-1:0]     font_row,
	input  logic                           out_stall,
	output logic                           advance,
	output logic                           out_valid,
	output logic [tmg_pkg::PIX_W-1:0]      pixels,
	output logic                           blanked
);
	import tmg_pkg::*;

	logic              out_valid_q;
	logic [PIX_W-1:0]  pixels_q;
	logic              blanked_q;
	logic [FONT_W-1:0] bits;

	always_comb begin
		if (s1.blank) begin
			bits = '0;
		end else begin
			bits = s1.row_ok ? font_row : '0;
			if (s1.bold) begin
				bits = bits | (bits >> 1);
			end
			if (s1.ul_fill) begin
				bits = '1;
			end
		end
	end

	assign advance = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid) begin
			blanked_q <= s1.blanked;
			pixels_q  <= s1.blanked ? '0 : spread_pixels(bits, s1.fg, s1.bg);
		end
	end

	assign out_valid = out_valid_q;
	assign pixels    = pixels_q;
	assign blanked   = blanked_q;

endmodule

// ===== hdl/text_mode_glyph_row_renderer.sv =====
// Text-mode glyph row renderer: font store, cursor logic and the two-stage render pipeline.
// An accepted render word passes through the stage-one register and then the output register
// before out_valid rises, and an output stall can hold it in either.
// Throughput: one word per cycle unless the output stalls; font writes and frame ticks share that pace.
// The font store RAM has one write and one read port, which sets the one-word-per-cycle pace.
// Reset clears the pipeline valids and the blink counter and loads the register defaults.
// The font store is not cleared; a glyph row must be written before it is rendered.
module text_mode_glyph_row_renderer (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [tmg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tmg_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Input channel.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [tmg_pkg::OP_W-1:0]         op,
	input  logic [tmg_pkg::GLYPH_W-1:0]      glyph,
	input  logic [tmg_pkg::GROW_W-1:0]       glyph_row,
	input  logic [tmg_pkg::FONT_W-1:0]       font_bits,
	input  logic [tmg_pkg::TROW_W-1:0]       text_row,
	input  logic [tmg_pkg::COL_W-1:0]        column,
	input  logic [tmg_pkg::COLOR_W-1:0]      fore,
	input  logic [tmg_pkg::COLOR_W-1:0]      back,
	input  logic                             invert,
	input  logic                             blank,
	input  logic                             bold,
	input  logic                             underline,
	// Output channel.
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tmg_pkg::PIX_W-1:0]        pixels,
	output logic                             blanked
);
	import tmg_pkg::*;

	cfg_t              cfg;
	logic              blink_on;
	logic              accept;
	logic              is_write;
	logic              is_tick;
	logic              is_render;
	logic              row_ok;
	logic              cursor_hit;
	logic              advance;
	logic [STORE_AW-1:0] store_addr;
	logic [FONT_W-1:0] font_row;
	render_t           render_d;
	render_t           s1_q;
	logic              s1_valid_q;

	// The first stage can take a new word whenever it is empty or is moving on
	// into the output register this cycle. A word held in stage one keeps the
	// RAM read data stable because no new read is issued until it moves.
	assign in_stall  = s1_valid_q && !advance;
	assign accept    = in_valid && !in_stall;
	assign is_write  = accept && (op_t'(op) == OP_FONT_WRITE);
	assign is_tick   = accept && (op_t'(op) == OP_FRAME_TICK);
	assign is_render = accept && (op_t'(op) == OP_RENDER);

	assign store_addr = {glyph, glyph_row};
	assign row_ok     = {1'b0, glyph_row} < (GROW_W+1)'(GLYPH_HEIGHT);

	tmg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (is_tick),
		.cfg       (cfg),
		.blink_on  (blink_on)
	);

	// Font rows that lie beyond the glyph height are never stored. A write and a
	// later read of the same row are always at different clock edges, so the
	// read sees the written data without any bypass.
	tmg_ram #(
		.WIDTH (FONT_W),
		.DEPTH (STORE_DEPTH)
	) u_font_store (
		.clk   (clk),
		.we    (is_write && row_ok),
		.waddr (store_addr),
		.wdata (font_bits),
		.re    (is_render),
		.raddr (store_addr),
		.rdata (font_row)
	);

	// Cell colors, cursor and visibility are all settled in the first stage,
	// while the font row is being read out of the store.
	assign cursor_hit = cfg.cursor_enable && blink_on
		&& (text_row == cfg.cursor_row) && (column == cfg.cursor_col);

	always_comb begin
		render_d.blanked = ({1'b0, text_row} >= cfg.rows_in_use)
			|| ({1'b0, text_row} >= (TROW_W+1)'(MAX_ROWS))
			|| ({1'b0, column} >= (COL_W+1)'(NUM_COLUMNS));
		if (cursor_hit) begin
			render_d.fg = cfg.cursor_back;
			render_d.bg = cfg.cursor_fore;
		end else if (invert) begin
			render_d.fg = back;
			render_d.bg = fore;
		end else begin
			render_d.fg = fore;
			render_d.bg = back;
		end
		render_d.row_ok  = row_ok;
		render_d.blank   = blank;
		render_d.bold    = bold;
		render_d.ul_fill = underline && ({1'b0, glyph_row} == (GROW_W+1)'(GLYPH_HEIGHT - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= is_render;
		end
	end

	always_ff @(posedge clk) begin
		if (is_render) begin
			s1_q <= render_d;
		end
	end

	tmg_pixel u_pixel (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid_q),
		.s1        (s1_q),
		.font_row  (font_row),
		.out_stall (out_stall),
		.advance   (advance),
		.out_valid (out_valid),
		.pixels    (pixels),
		.blanked   (blanked)
	);

	// A blanked word always carries all-zero pixels.
	a_blanked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && blanked |-> pixels == '0)
		else $error("blanked word with nonzero pixels");

	// The input side only stalls while stage one holds a word that cannot move.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q && out_valid && out_stall)
		else $error("input stalled without a blocked render word");

	// An accepted render word is in stage one on the next cycle.
	a_render_loads: assert property (@(posedge clk) disable iff (!arst_n)
		is_render |=> s1_valid_q)
		else $error("accepted render word lost from stage one");

	// A word held in stage one reaches the output as soon as the output frees up.
	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && advance |=> out_valid)
		else $error("stage one word did not reach the output register");

endmodule
